// ===== rtl/psd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, register map and types of the predictive sample
// decorrelator.
// ----------------------------------------------------------------------------
package psd_pkg;

   // sample and line geometry
   localparam int SAMPLE_W      = 16;
   localparam int ROW_MAX       = 4096;
   localparam int COL_W         = $clog2(ROW_MAX);
   localparam int WIDTH_W       = 13;
   localparam int ROW_MIN       = 3;

   // configuration register map (index = paddr[3:2])
   localparam int CSR_ADDR_W    = 4;
   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_MAX_VALUE = 2'd1;
   localparam logic [1:0] REG_ROW_WIDTH = 2'd2;

   // predictor modes
   localparam logic [2:0] MODE_NONE     = 3'd0;
   localparam logic [2:0] MODE_LEFT     = 3'd1;
   localparam logic [2:0] MODE_TWO_LEFT = 3'd2;
   localparam logic [2:0] MODE_MED      = 3'd3;
   localparam logic [2:0] MODE_FGIJ     = 3'd4;

   // divide by three: q = (x * DIV3_MULT) >> DIV3_SHIFT, exact for x < 2**19
   localparam int          DIV3_SHIFT = 19;
   localparam logic [17:0] DIV3_MULT  = 18'd174763;

   // neighborhood of one sample, handed from the pipeline to the predictor
   typedef struct packed {
      logic [SAMPLE_W-1:0] w;
      logic [SAMPLE_W-1:0] ww;
      logic [SAMPLE_W-1:0] nw;
      logic [SAMPLE_W-1:0] n;
      logic                first_row;
      logic                col_zero;
      logic                col_one;
   } nbr_type;

endpackage

// ===== rtl/psd_line_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_line_mem
// Previous-row sample store: one port, read-first, registered read data.
// ----------------------------------------------------------------------------
module psd_line_mem
   import psd_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [COL_W-1:0]    addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [ROW_MAX];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // read old value and write new sample at the same column
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psd_predictor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_predictor
// Forms the prediction of one sample from its causal neighbors for the
// selected mode.
// ----------------------------------------------------------------------------
module psd_predictor
   import psd_pkg::*;
(
   input  logic [2:0]          mode,
   input  nbr_type             nbr,
   output logic [SAMPLE_W-1:0] pred
);

   logic [SAMPLE_W:0]     sum_w_ww;
   logic [SAMPLE_W:0]     sum_w_ww_rnd;
   logic [SAMPLE_W+1:0]   sum_three;
   logic [SAMPLE_W+1:0]   sum_four;
   logic [35:0]           div3_prod;
   logic [SAMPLE_W-1:0]   div3_q;
   logic [SAMPLE_W-1:0]   med_hi;
   logic [SAMPLE_W-1:0]   med_lo;
   logic [SAMPLE_W:0]     med_grad;
   logic [SAMPLE_W-1:0]   med_p;
   logic [SAMPLE_W-1:0]   col0_p;

   // neighbor sums
   assign sum_w_ww     = {1'b0, nbr.w} + {1'b0, nbr.ww};
   assign sum_w_ww_rnd = sum_w_ww + (SAMPLE_W+1)'(1);
   assign sum_three    = {2'b0, nbr.n} + {2'b0, nbr.nw} + {2'b0, nbr.ww};
   assign sum_four     = {1'b0, sum_w_ww} + {2'b0, nbr.n} + {2'b0, nbr.nw};

   // divide by three through the reciprocal
   assign div3_prod = 36'(sum_three) * 36'(DIV3_MULT);
   assign div3_q    = div3_prod[DIV3_SHIFT+SAMPLE_W-1:DIV3_SHIFT];

   // median edge detector
   assign med_hi   = (nbr.w > nbr.n) ? nbr.w : nbr.n;
   assign med_lo   = (nbr.w > nbr.n) ? nbr.n : nbr.w;
   assign med_grad = {1'b0, nbr.w} + {1'b0, nbr.n} - {1'b0, nbr.nw};

   always_comb begin
      priority if (nbr.nw >= med_hi) begin
         med_p = med_lo;
      end else if (nbr.nw <= med_lo) begin
         med_p = med_hi;
      end else begin
         med_p = med_grad[SAMPLE_W-1:0];
      end
   end

   // first column predicts from above, or zero on the first row
   assign col0_p = nbr.first_row ? '0 : nbr.n;

   // mode select
   always_comb begin
      unique case (mode)
         MODE_LEFT: begin
            pred = nbr.w;
         end
         MODE_TWO_LEFT: begin
            pred = sum_w_ww_rnd[SAMPLE_W:1];
         end
         MODE_MED: begin
            if (nbr.col_zero) begin
               pred = col0_p;
            end else begin
               pred = nbr.first_row ? nbr.w : med_p;
            end
         end
         MODE_FGIJ: begin
            if (nbr.col_zero) begin
               pred = col0_p;
            end else if (nbr.col_one) begin
               pred = nbr.first_row ? nbr.w : div3_q;
            end else begin
               pred = nbr.first_row ? sum_w_ww[SAMPLE_W:1] : sum_four[SAMPLE_W+1:2];
            end
         end
         default: begin
            pred = '0;
         end
      endcase
   end

endmodule

// ===== rtl/psd_err_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_err_map
// Maps the prediction error to a non-negative code folded around the
// prediction (other modes pass the sample), flags samples over the maximum.
// ----------------------------------------------------------------------------
module psd_err_map
   import psd_pkg::*;
(
   input  logic [2:0]          mode,
   input  logic [SAMPLE_W-1:0] max_value,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] pred,
   output logic [SAMPLE_W-1:0] coded,
   output logic                range_error
);

   logic [SAMPLE_W-1:0] pred_sat;
   logic                neg;
   logic [SAMPLE_W-1:0] mag;
   logic [SAMPLE_W-1:0] room_up;
   logic [SAMPLE_W-1:0] theta;
   logic [SAMPLE_W:0]   fold_code;
   logic [SAMPLE_W:0]   mapped;
   logic                predicted;

   // saturate prediction to the legal range
   assign pred_sat = (pred > max_value) ? max_value : pred;

   // error magnitude and sign
   assign neg = sample < pred_sat;
   assign mag = neg ? (pred_sat - sample) : (sample - pred_sat);

   // symmetric folding range around the prediction
   assign room_up = max_value - pred_sat;
   assign theta   = (room_up < pred_sat) ? room_up : pred_sat;

   assign fold_code = {mag, 1'b0} - (SAMPLE_W+1)'(neg);
   assign mapped    = (mag <= theta) ? fold_code : ({1'b0, theta} + {1'b0, mag});

   assign predicted   = (mode >= MODE_LEFT) && (mode <= MODE_FGIJ);
   assign range_error = sample > max_value;

   // output select
   always_comb begin
      priority if (range_error) begin
         coded = '0;
      end else if (predicted) begin
         coded = mapped[SAMPLE_W-1:0];
      end else begin
         coded = sample;
      end
   end

endmodule

// ===== rtl/predictive_sample_decorrelator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// predictive_sample_decorrelator
// Lossless predictor front end: predicts each raster sample from its causal
// neighbors and emits the folded prediction error.
//
// Usage:
//  - Requests (req_sample, req_block_start) enter on a valid/ready channel,
//    one sample in raster order per request; block_start restarts the
//    prediction at row 0, column 0.
//  - Results (rsp_coded, rsp_range_error) leave on a valid/ready channel,
//    exactly one per request, in order.
//  - Throughput is one request per cycle while the receiver takes results.
//    Results pass through three register stages: line store read,
//    prediction, error mapping into the output register.
//  - The previous row is kept in a 4096-entry single-port line store, read
//    and written at the same column in the cycle a request is accepted; the
//    left neighbors are held in registers.
//  - When the receiver stalls, the pipeline keeps taking requests until its
//    three stages are full, then drops req_ready.
//  - Synchronous reset clears the pipeline and the prediction state and
//    loads mode none, max_value 65535 and row_width 3. The line store is not
//    cleared: a block uses only columns it wrote unless row_width grows.
//  - Configuration registers (APB style, index = paddr[3:2]): mode,
//    max_value, row_width; write them only while the block is idle.
// ----------------------------------------------------------------------------
module predictive_sample_decorrelator
   import psd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic                  req_block_start,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SAMPLE_W-1:0]   rsp_coded,
   output logic                  rsp_range_error,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   // configuration registers
   logic [2:0]          mode_ff;
   logic [SAMPLE_W-1:0] max_value_ff;
   logic [WIDTH_W-1:0]  row_width_ff;
   logic                csr_wr;
   logic [1:0]          csr_index;

   // prediction state
   logic [COL_W-1:0]    col_ff;
   logic                first_row_ff;
   logic [SAMPLE_W-1:0] west_ff;
   logic [SAMPLE_W-1:0] west_west_ff;
   logic                fresh_ff;

   // stage a: neighbors captured, line store data arriving
   logic                a_valid_ff;
   logic [SAMPLE_W-1:0] a_sample_ff;
   logic [SAMPLE_W-1:0] a_w_ff;
   logic [SAMPLE_W-1:0] a_ww_ff;
   logic [SAMPLE_W-1:0] a_nw_ff;
   logic                a_first_row_ff;
   logic                a_col_zero_ff;
   logic                a_col_one_ff;

   // stage b: prediction
   logic                b_valid_ff;
   logic [SAMPLE_W-1:0] b_sample_ff;
   logic [SAMPLE_W-1:0] b_pred_ff;

   // output register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_coded_ff;
   logic                rsp_range_error_ff;

   // pipeline control
   logic                out_adv;
   logic                b_adv;
   logic                a_adv;
   logic                accept;

   // current sample position after an optional block restart
   logic [COL_W-1:0]    col_cur;
   logic                first_row_cur;
   logic [SAMPLE_W-1:0] w_cur;
   logic [SAMPLE_W-1:0] ww_cur;
   logic [SAMPLE_W-1:0] nw_cur;
   logic [WIDTH_W-1:0]  width_sat;
   logic [WIDTH_W-1:0]  col_next;
   logic                row_end;

   logic [SAMPLE_W-1:0] north;
   nbr_type             nbr;
   logic [SAMPLE_W-1:0] pred;
   logic [SAMPLE_W-1:0] map_coded;
   logic                map_range_error;

   // configuration port
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NONE;
         max_value_ff <= '1;
         row_width_ff <= WIDTH_W'(ROW_MIN);
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_MODE:      mode_ff      <= pwdata[2:0];
            REG_MAX_VALUE: max_value_ff <= pwdata[SAMPLE_W-1:0];
            REG_ROW_WIDTH: row_width_ff <= pwdata[WIDTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MODE:      prdata = {29'b0, mode_ff};
         REG_MAX_VALUE: prdata = {16'b0, max_value_ff};
         REG_ROW_WIDTH: prdata = {19'b0, row_width_ff};
         default:       prdata = '0;
      endcase
   end

   // stall propagation, bubbles collapse
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign b_adv     = !b_valid_ff || out_adv;
   assign a_adv     = !a_valid_ff || b_adv;
   assign req_ready = a_adv;
   assign accept    = req_valid && a_adv;

   // neighbor state for the incoming sample
   assign col_cur       = req_block_start ? '0 : col_ff;
   assign first_row_cur = req_block_start || first_row_ff;
   assign w_cur         = req_block_start ? '0 : west_ff;
   assign ww_cur        = req_block_start ? '0 : west_west_ff;
   assign nw_cur        = (req_block_start || fresh_ff) ? '0 : north;

   // row width clamped between three and the line store size
   always_comb begin
      priority if (row_width_ff < WIDTH_W'(ROW_MIN)) begin
         width_sat = WIDTH_W'(ROW_MIN);
      end else if (row_width_ff > WIDTH_W'(ROW_MAX)) begin
         width_sat = WIDTH_W'(ROW_MAX);
      end else begin
         width_sat = row_width_ff;
      end
   end

   assign col_next = {1'b0, col_cur} + WIDTH_W'(1);
   assign row_end  = col_next >= width_sat;

   // prediction state update
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         west_ff      <= '0;
         west_west_ff <= '0;
         fresh_ff     <= 1'b1;
      end else if (accept) begin
         col_ff       <= row_end ? '0 : col_next[COL_W-1:0];
         first_row_ff <= first_row_cur && !row_end;
         west_ff      <= req_sample;
         west_west_ff <= w_cur;
         fresh_ff     <= 1'b0;
      end
   end

   // previous row store
   psd_line_mem u_line_mem (
      .clock   (clock),
      .en      (accept),
      .addr    (col_cur),
      .wr_data (req_sample),
      .rd_data (north)
   );

   // stage a
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_adv) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sample_ff    <= req_sample;
         a_w_ff         <= w_cur;
         a_ww_ff        <= ww_cur;
         a_nw_ff        <= nw_cur;
         a_first_row_ff <= first_row_cur;
         a_col_zero_ff  <= col_cur == COL_W'(0);
         a_col_one_ff   <= col_cur == COL_W'(1);
      end
   end

   assign nbr.w         = a_w_ff;
   assign nbr.ww        = a_ww_ff;
   assign nbr.nw        = a_nw_ff;
   assign nbr.n         = north;
   assign nbr.first_row = a_first_row_ff;
   assign nbr.col_zero  = a_col_zero_ff;
   assign nbr.col_one   = a_col_one_ff;

   psd_predictor u_predictor (
      .mode (mode_ff),
      .nbr  (nbr),
      .pred (pred)
   );

   // stage b
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && a_valid_ff) begin
         b_sample_ff <= a_sample_ff;
         b_pred_ff   <= pred;
      end
   end

   psd_err_map u_err_map (
      .mode        (mode_ff),
      .max_value   (max_value_ff),
      .sample      (b_sample_ff),
      .pred        (b_pred_ff),
      .coded       (map_coded),
      .range_error (map_range_error)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && b_valid_ff) begin
         rsp_coded_ff       <= map_coded;
         rsp_range_error_ff <= map_range_error;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coded       = rsp_coded_ff;
   assign rsp_range_error = rsp_range_error_ff;

endmodule

// ===== verif/predictive_sample_decorrelator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// predictive_sample_decorrelator_tb
// Self-checking bench for the sample decorrelator. A scoreboard object
// carries its own copy of the prediction state and the register file, folds
// every accepted request into an expected code and checks the result stream
// in order. Stimulus is a short directed pass over the modes and corner
// cases, then random settings with raster blocks of random content, and two
// passes at the widest row span. Sender bursts and receiver stalls vary per
// setting.
// ----------------------------------------------------------------------------
module predictive_sample_decorrelator_tb
   import psd_pkg::*;
();

   localparam int          CYCLE_LIMIT     = 200000;
   localparam int          RANDOM_REQUESTS = 400;
   localparam int          REPORT_MAX      = 10;
   localparam logic [2:0]  MODE_SPARE_LO   = 3'd5;
   localparam logic [2:0]  MODE_SPARE_HI   = 3'd7;
   localparam int unsigned SAMPLE_TOP      = 65535;
   localparam int unsigned WIDTH_TOP       = 8191;

   typedef struct packed {
      logic [SAMPLE_W-1:0] coded;
      logic                range_error;
   } coded_result_type;

   // prediction model and in-order result check
   class decorrelator_scoreboard;
      logic [2:0]         mode;
      logic [SAMPLE_W-1:0] max_value;
      logic [WIDTH_W-1:0] row_width;
      int unsigned        line_store [ROW_MAX];
      int unsigned        west, west_west, north_west, column;
      bit                 first_row;
      coded_result_type   expected_q [$];
      int unsigned        mismatches, checked, range_flags;
      int unsigned        mode_hits [8];

      function new();
         mode      = MODE_NONE;
         max_value = SAMPLE_W'(SAMPLE_TOP);
         row_width = WIDTH_W'(ROW_MIN);
         foreach (line_store[i]) line_store[i] = 0;
         foreach (mode_hits[i]) mode_hits[i] = 0;
         mismatches  = 0;
         checked     = 0;
         range_flags = 0;
         restart();
      endfunction

      function void restart();
         west       = 0;
         west_west  = 0;
         north_west = 0;
         column     = 0;
         first_row  = 1'b1;
      endfunction

      function void write_reg(logic [1:0] idx, int unsigned value);
         case (idx)
            REG_MODE:      mode      = value[2:0];
            REG_MAX_VALUE: max_value = value[SAMPLE_W-1:0];
            REG_ROW_WIDTH: row_width = value[WIDTH_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // fold the error into a non-negative code around the prediction
      function logic [SAMPLE_W-1:0] fold_error(int unsigned s, int unsigned p,
                                               int unsigned m);
         int unsigned a, theta;
         bit          neg;
         if (p > m) p = m;
         if (s >= p) begin
            a   = s - p;
            neg = 1'b0;
         end else begin
            a   = p - s;
            neg = 1'b1;
         end
         theta = (m - p < p) ? m - p : p;
         if (a <= theta) return SAMPLE_W'((a << 1) - neg);
         return SAMPLE_W'(theta + a);
      endfunction

      function int unsigned median_edge(int unsigned w, int unsigned n,
                                        int unsigned nw);
         int unsigned hi, lo;
         hi = (w > n) ? w : n;
         lo = (w > n) ? n : w;
         if (nw >= hi) return lo;
         if (nw <= lo) return hi;
         return w + n - nw;
      endfunction

      // one accepted request: predict, fold, advance the raster position
      function void note_request(logic [SAMPLE_W-1:0] sample, logic block_start);
         int unsigned      s, n, p, span;
         coded_result_type r;
         if (block_start) restart();
         span = row_width;
         if (span < ROW_MIN) span = ROW_MIN;
         if (span > ROW_MAX) span = ROW_MAX;
         s = sample;
         n = line_store[column];
         p = 0;
         case (mode)
            MODE_LEFT:     p = west;
            MODE_TWO_LEFT: p = (west + west_west + 1) >> 1;
            MODE_MED: begin
               if (column == 0)   p = first_row ? 0 : n;
               else               p = first_row ? west
                                                : median_edge(west, n, north_west);
            end
            MODE_FGIJ: begin
               if (column == 0)      p = first_row ? 0 : n;
               else if (column == 1) p = first_row ? west
                                                   : (n + north_west + west_west) / 3;
               else                  p = first_row ? (west + west_west) >> 1
                                                   : (west + west_west + n + north_west) >> 2;
            end
            default: p = 0;
         endcase
         r.range_error = (s > max_value);
         if (r.range_error)
            r.coded = '0;
         else if (mode >= MODE_LEFT && mode <= MODE_FGIJ)
            r.coded = fold_error(s, p, max_value);
         else
            r.coded = sample;
         north_west         = n;
         line_store[column] = s;
         west_west          = west;
         west               = s;
         column++;
         if (column >= span) begin
            column    = 0;
            first_row = 1'b0;
         end
         mode_hits[mode]++;
         if (r.range_error) range_flags++;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [SAMPLE_W-1:0] coded, logic range_error);
         coded_result_type want;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: result with no request outstanding: coded %h range_error %b",
                        $realtime, coded, range_error);
            return;
         end
         want = expected_q.pop_front();
         if (want.coded !== coded || want.range_error !== range_error) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: result %0d: coded exp %h got %h, range_error exp %b got %b",
                        $realtime, checked, want.coded, coded, want.range_error,
                        range_error);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample      = '0;
   logic                  req_block_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_coded;
   logic                  rsp_range_error;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [31:0]           pwdata          = '0;
   logic [31:0]           prdata;
   logic                  pready;

   decorrelator_scoreboard sb = new();

   int unsigned cycles       = 0;
   int unsigned burst_left   = 0;
   int unsigned last_sample  = 0;
   int unsigned row_span     = ROW_MIN;
   int unsigned settings     = 0;
   bit          restart_due  = 1'b0;
   bit          steady_send  = 1'b0;
   logic [1:0]  stall_style  = 2'd0;
   logic [3:0]  stall_tick   = '0;

   predictive_sample_decorrelator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coded       (rsp_coded),
      .rsp_range_error (rsp_range_error),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // both handshakes observed on the same edge the block sees them
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.note_request(req_sample, req_block_start);
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_coded, rsp_range_error);
   end

   // receiver stall pattern, style chosen per setting
   always @(posedge clock) begin
      stall_tick <= stall_tick + 4'd1;
      case (stall_style)
         2'd0:    rsp_ready <= 1'b1;
         2'd1:    rsp_ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_ready <= (stall_tick < 4'd5);
         default: rsp_ready <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [1:0] idx, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   // a wider row reads columns not yet written, so restart the block
   task automatic set_row_width(input int unsigned value);
      int unsigned span;
      csr_write(REG_ROW_WIDTH, value);
      span = value & WIDTH_TOP;
      if (span < ROW_MIN) span = ROW_MIN;
      if (span > ROW_MAX) span = ROW_MAX;
      if (span > row_span) restart_due = 1'b1;
      row_span = span;
   endtask

   // one request, inside bursts of random length with random gaps
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic block_start);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = steady_send ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_sample      <= sample;
      req_block_start <= block_start | restart_due;
      restart_due      = 1'b0;
      last_sample      = sample;
      do @(posedge clock); while (!req_ready);
   endtask

   // one edge first so the monitor has logged the last accepted request
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // smooth image content, random jumps, extremes and over-range values
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int          v;
      int unsigned r, top;
      r   = $urandom_range(0, 99);
      top = sb.max_value;
      if (r < 40) begin
         v = int'(last_sample) + int'($urandom_range(0, 16)) - 8;
         if (v < 0) v = 0;
         if (v > int'(top)) v = int'(top);
         return SAMPLE_W'(v);
      end
      if (r < 72) return SAMPLE_W'($urandom_range(0, top));
      if (r < 82) return ($urandom_range(0, 1) != 0) ? SAMPLE_W'(top) : '0;
      if (r < 92 && top < SAMPLE_TOP) return SAMPLE_W'($urandom_range(top + 1, SAMPLE_TOP));
      return SAMPLE_W'($urandom());
   endfunction

   // new register setting, each register changed only some of the time unless write_all is set
   task automatic pick_setting(input bit write_all);
      int unsigned r;
      if (write_all || $urandom_range(0, 2) != 0) begin
         r = $urandom_range(0, 9);
         if (r < 8)      csr_write(REG_MODE, $urandom_range(MODE_LEFT, MODE_FGIJ));
         else if (r < 9) csr_write(REG_MODE, MODE_NONE);
         else            csr_write(REG_MODE, $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end
      if (write_all || $urandom_range(0, 2) == 0) begin
         r = $urandom_range(0, 9);
         if (r < 4)      csr_write(REG_MAX_VALUE, SAMPLE_TOP);
         else if (r < 5) csr_write(REG_MAX_VALUE, 1);
         else if (r < 7) csr_write(REG_MAX_VALUE, $urandom_range(2, 255));
         else            csr_write(REG_MAX_VALUE, $urandom_range(256, SAMPLE_TOP));
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         r = $urandom_range(0, 19);
         if (r < 14)      set_row_width($urandom_range(ROW_MIN, 12));
         else if (r < 16) set_row_width($urandom_range(0, ROW_MIN - 1));
         else if (r < 19) set_row_width($urandom_range(13, 64));
         else             set_row_width($urandom_range(ROW_MAX, WIDTH_TOP));
      end
      stall_style <= 2'($urandom_range(0, 3));
      steady_send  = ($urandom_range(0, 3) == 0);
      settings++;
   endtask

   initial begin
      int unsigned random_sent, count;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pass-through at reset settings, both extremes and alternating bits
      send_sample(16'h0000, 1'b1);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b0);
      wait_idle();
      // spare mode code behaves as pass-through
      csr_write(REG_MODE, MODE_SPARE_HI);
      send_sample(16'h8001, 1'b0);
      wait_idle();
      // left neighbor with full-scale swings
      csr_write(REG_MODE, MODE_LEFT);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      wait_idle();
      // two-left mean rounds up
      csr_write(REG_MODE, MODE_TWO_LEFT);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0002, 1'b0);
      wait_idle();
      // median edge, width clamped up to three, low ceiling with one over-range
      set_row_width(0);
      csr_write(REG_MAX_VALUE, 1000);
      csr_write(REG_MODE, MODE_MED);
      send_sample(16'd700, 1'b1);
      send_sample(16'd1001, 1'b0);
      send_sample(16'd20, 1'b0);
      send_sample(16'd900, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd1000, 1'b0);
      wait_idle();
      // ceiling dropped below stored neighbors, prediction saturates
      csr_write(REG_MAX_VALUE, 1);
      csr_write(REG_MODE, MODE_FGIJ);
      send_sample(16'd1, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      wait_idle();
      // four-neighbor over two rows of four
      csr_write(REG_MAX_VALUE, SAMPLE_TOP);
      set_row_width(4);
      send_sample(16'd100, 1'b1);
      send_sample(16'd110, 1'b0);
      send_sample(16'hFFF0, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd90, 1'b0);
      send_sample(16'd120, 1'b0);
      send_sample(16'd60000, 1'b0);
      send_sample(16'd7, 1'b0);
      wait_idle();

      // random settings, each followed by a raster run of random content
      while (random_sent < RANDOM_REQUESTS) begin
         pick_setting(random_sent == 0);
         count = $urandom_range(12, 60);
         repeat (count) send_sample(pick_sample(), $urandom_range(0, 49) == 0);
         random_sent += count;
         wait_idle();
      end

      // widest row setting saturates to the line store size
      csr_write(REG_MODE, MODE_FGIJ);
      csr_write(REG_MAX_VALUE, SAMPLE_TOP);
      set_row_width(WIDTH_TOP);
      stall_style <= 2'd1;
      steady_send  = 1'b0;
      settings++;
      repeat (40) send_sample(pick_sample(), 1'b0);
      wait_idle();
      // exact maximum width, same span, the row continues
      set_row_width(ROW_MAX);
      csr_write(REG_MODE, MODE_MED);
      settings++;
      repeat (16) send_sample(pick_sample(), 1'b0);
      wait_idle();

      // let any stray result surface
      repeat (12) @(posedge clock);

      $display("run covered %0d results over %0d settings, %0d over-range samples",
               sb.checked, settings, sb.range_flags);
      $display("requests per mode code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
               sb.mode_hits[4], sb.mode_hits[5], sb.mode_hits[6], sb.mode_hits[7]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/psd_pkg.sv
rtl/psd_line_mem.sv
rtl/psd_predictor.sv
rtl/psd_err_map.sv
rtl/predictive_sample_decorrelator.sv
verif/predictive_sample_decorrelator_tb.sv
